### hw/rtl/acarb_pkg.sv
// Shared types, codes and helper functions of the appliance command arbiter.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package acarb_pkg;

    localparam int unsigned ORIGINS_DEF = 4;
    localparam int unsigned ID_W        = 32;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_NOCHANGE = 3'd1;
    localparam status_t ST_BADVALUE = 3'd2;
    localparam status_t ST_BADTRANS = 3'd3;
    localparam status_t ST_DUP      = 3'd4;

    typedef logic [1:0] req_t;
    localparam req_t REQ_CMD    = 2'd0;
    localparam req_t REQ_TOGGLE = 2'd1;
    localparam req_t REQ_TICK   = 2'd2;
    localparam req_t REQ_DONE   = 2'd3;

    typedef logic [3:0] kind_t;
    localparam kind_t K_POWER  = 4'd0;
    localparam kind_t K_FAN    = 4'd1;
    localparam kind_t K_MIST   = 4'd2;
    localparam kind_t K_BREEZE = 4'd3;
    localparam kind_t K_SWING  = 4'd4;
    localparam kind_t K_DIR    = 4'd5;
    localparam kind_t K_POS    = 4'd6;
    localparam kind_t K_TIMER  = 4'd7;
    localparam kind_t K_CLEAR  = 4'd8;

    localparam logic [1:0] ORG_SYSTEM = 2'd0;

    typedef struct packed {
        req_t              req_type;
        logic [1:0]        origin;
        logic [ID_W-1:0]   request_id;
        kind_t             cmd_kind;
        logic signed [7:0] cmd_value;
        logic [31:0]       uptime_seconds;
    } item_t;

    typedef struct packed {
        logic              power;
        logic [2:0]        fan;
        logic              mist;
        logic [2:0]        breeze;
        logic [1:0]        swing;
        logic signed [1:0] direction;
        logic [11:0]       remaining;
        logic [11:0]       duration;
        logic              pending;
        logic [31:0]       timer_mark;
        logic [31:0]       now_uptime;
        logic [31:0]       revision;
        logic [1:0]        source;
    } ctl_state_t;

    localparam ctl_state_t CTL_RESET = '{
        power: 1'b0, fan: 3'd1, mist: 1'b0, breeze: 3'd0, swing: 2'd0,
        direction: 2'sd0, remaining: 12'd0, duration: 12'd0, pending: 1'b0,
        timer_mark: 32'd0, now_uptime: 32'd0, revision: 32'd0, source: ORG_SYSTEM
    };

    typedef struct packed {
        logic org_ok;
        logic dup;
    } dedup_look_t;

    typedef struct packed {
        logic            wr_en;
        logic [1:0]      origin;
        logic [ID_W-1:0] id;
    } dedup_upd_t;

    function automatic logic value_ok(kind_t k, logic signed [7:0] v);
        logic ok;
        case (k)
            K_POWER:  ok = v inside {8'sd0, 8'sd1};
            K_FAN:    ok = (v >= 8'sd1) && (v <= 8'sd5);
            K_MIST:   ok = (v >= 8'sd0) && (v <= 8'sd1);
            K_BREEZE: ok = (v >= 8'sd0) && (v <= 8'sd6);
            K_SWING:  ok = (v >= 8'sd0) && (v <= 8'sd3);
            K_DIR:    ok = (v >= -8'sd1) && (v <= 8'sd1);
            K_POS:    ok = (v >= -8'sd3) && (v <= 8'sd3);
            K_TIMER:  ok = v inside {8'sd0, 8'sd15, 8'sd30, 8'sd45, 8'sd60};
            K_CLEAR:  ok = (v == 8'sd0);
            default:  ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Minutes to seconds for the accepted timer settings only.
    function automatic logic [11:0] timer_secs(logic signed [7:0] v);
        logic [11:0] s;
        case (v)
            8'sd15:  s = 12'd900;
            8'sd30:  s = 12'd1800;
            8'sd45:  s = 12'd2700;
            8'sd60:  s = 12'd3600;
            default: s = 12'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/acarb_dedup.sv
// Per-origin request serial history and the duplicate and origin range checks.
// Depends on acarb_pkg.
`default_nettype none

module acarb_dedup #(
    parameter int unsigned ORIGINS = acarb_pkg::ORIGINS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [1:0]                look_org,
    input  wire logic [acarb_pkg::ID_W-1:0] look_id,
    output acarb_pkg::dedup_look_t         look,
    input  wire acarb_pkg::dedup_upd_t     upd
);

    localparam int unsigned IDX_W = (ORIGINS > 1) ? $clog2(ORIGINS) : 1;
    localparam int unsigned OW    = IDX_W + 2;

    logic [ORIGINS-1:0]          seen_reg;
    logic [acarb_pkg::ID_W-1:0]  last_id_reg [ORIGINS];
    logic [OW-1:0]               look_wide;
    logic [OW-1:0]               upd_wide;
    logic [IDX_W-1:0]            look_idx;
    logic [IDX_W-1:0]            upd_idx;
    logic [acarb_pkg::ID_W-1:0]  diff;

    assign look_wide = OW'(look_org);
    assign upd_wide  = OW'(upd.origin);
    assign look_idx  = look_wide[IDX_W-1:0];
    assign upd_idx   = upd_wide[IDX_W-1:0];

    // A serial counts as seen when it does not lie ahead of the last one in wrapping order.
    assign diff        = look_id - last_id_reg[look_idx];
    assign look.org_ok = look_wide < OW'(ORIGINS);
    assign look.dup    = look.org_ok && (look_id != '0) && seen_reg[look_idx]
                         && ((diff == '0) || diff[acarb_pkg::ID_W-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (upd.wr_en) begin
            seen_reg[upd_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.wr_en) begin
            last_id_reg[upd_idx] <= upd.id;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/acarb_eval.sv
// Next-state and status logic for one request: command checks, apply and timer countdown.
// Depends on acarb_pkg; the duplicate lookup comes from acarb_dedup.
`default_nettype none

module acarb_eval (
    input  wire acarb_pkg::item_t       item,
    input  wire acarb_pkg::ctl_state_t  cur,
    input  wire logic                   lock,
    input  wire acarb_pkg::dedup_look_t look,
    output acarb_pkg::ctl_state_t       nxt,
    output acarb_pkg::status_t          status,
    output acarb_pkg::dedup_upd_t       upd
);

    logic [1:0]                 c_org;
    logic [acarb_pkg::ID_W-1:0] c_rid;
    acarb_pkg::kind_t           c_kind;
    logic signed [7:0]          c_val;
    logic                       c_org_ok;
    logic                       c_dup;
    logic                       p;
    logic                       chg;
    logic [11:0]                secs;
    logic [31:0]                elapsed;
    logic                       expire;

    always_comb begin
        c_org    = item.origin;
        c_rid    = item.request_id;
        c_kind   = item.cmd_kind;
        c_val    = item.cmd_value;
        c_org_ok = look.org_ok;
        c_dup    = look.dup;
        if (item.req_type == acarb_pkg::REQ_TOGGLE) begin
            c_kind = acarb_pkg::K_POWER;
            c_val  = cur.power ? 8'sd0 : 8'sd1;
        end else if (item.req_type == acarb_pkg::REQ_DONE) begin
            c_org    = acarb_pkg::ORG_SYSTEM;
            c_rid    = '0;
            c_kind   = acarb_pkg::K_POWER;
            c_val    = 8'sd0;
            c_org_ok = 1'b1;
            c_dup    = 1'b0;
        end
    end

    assign p       = (c_val != 8'sd0);
    assign secs    = acarb_pkg::timer_secs(c_val);
    assign elapsed = item.uptime_seconds - cur.timer_mark;
    assign expire  = (elapsed[31:12] != '0) || (elapsed[11:0] >= cur.remaining);

    always_comb begin
        nxt        = cur;
        status     = acarb_pkg::ST_NOCHANGE;
        upd.wr_en  = 1'b0;
        upd.origin = c_org;
        upd.id     = c_rid;
        chg        = 1'b0;
        if (item.req_type == acarb_pkg::REQ_TICK) begin
            nxt.now_uptime = item.uptime_seconds;
            nxt.timer_mark = item.uptime_seconds;
            if (cur.power && (cur.remaining != '0) && !cur.pending && (elapsed != '0)) begin
                if (expire) begin
                    nxt.remaining = '0;
                    nxt.swing     = '0;
                    nxt.direction = '0;
                    nxt.pending   = 1'b1;
                end else begin
                    nxt.remaining = cur.remaining - elapsed[11:0];
                end
                nxt.revision = cur.revision + 32'd1;
                nxt.source   = acarb_pkg::ORG_SYSTEM;
                status       = acarb_pkg::ST_OK;
            end
        end else if ((item.req_type == acarb_pkg::REQ_DONE) && !cur.pending) begin
            status = acarb_pkg::ST_BADTRANS;
        end else if (!c_org_ok) begin
            status = acarb_pkg::ST_BADVALUE;
        end else if ((c_org != acarb_pkg::ORG_SYSTEM) && (c_rid == '0)) begin
            status = acarb_pkg::ST_BADVALUE;
        end else if ((c_org != acarb_pkg::ORG_SYSTEM) && lock) begin
            status = acarb_pkg::ST_BADTRANS;
        end else if (c_dup) begin
            status = acarb_pkg::ST_DUP;
        end else if (!acarb_pkg::value_ok(c_kind, c_val)) begin
            status = acarb_pkg::ST_BADVALUE;
        end else if ((c_kind != acarb_pkg::K_POWER) && (c_kind != acarb_pkg::K_CLEAR)
                     && !cur.power) begin
            status = acarb_pkg::ST_BADTRANS;
        end else begin
            upd.wr_en = (c_rid != '0);
            case (c_kind)
                acarb_pkg::K_POWER: begin
                    chg = (cur.power != p) || (cur.remaining != '0) || cur.pending;
                    nxt.remaining  = '0;
                    nxt.duration   = '0;
                    nxt.pending    = 1'b0;
                    nxt.timer_mark = cur.now_uptime;
                    if (chg) begin
                        nxt.power = p;
                        if (!p) begin
                            nxt.fan       = 3'd1;
                            nxt.mist      = 1'b0;
                            nxt.breeze    = '0;
                            nxt.swing     = '0;
                            nxt.direction = '0;
                        end
                    end
                end
                acarb_pkg::K_FAN: begin
                    chg = (cur.fan != c_val[2:0]) || (cur.breeze != '0);
                    nxt.fan    = c_val[2:0];
                    nxt.breeze = '0;
                end
                acarb_pkg::K_MIST: begin
                    chg      = (cur.mist != c_val[0]);
                    nxt.mist = c_val[0];
                end
                acarb_pkg::K_BREEZE: begin
                    chg        = (cur.breeze != c_val[2:0]);
                    nxt.breeze = c_val[2:0];
                end
                acarb_pkg::K_SWING: begin
                    chg       = (cur.swing != c_val[1:0]);
                    nxt.swing = c_val[1:0];
                end
                acarb_pkg::K_DIR: begin
                    chg           = 1'b1;
                    nxt.direction = c_val[1:0];
                    nxt.swing     = '0;
                end
                acarb_pkg::K_POS: begin
                    chg       = 1'b1;
                    nxt.swing = '0;
                end
                acarb_pkg::K_TIMER: begin
                    chg = !((cur.remaining == secs) && !cur.pending);
                    if (chg) begin
                        nxt.remaining  = secs;
                        nxt.duration   = secs;
                        nxt.timer_mark = cur.now_uptime;
                        nxt.pending    = 1'b0;
                    end
                end
                acarb_pkg::K_CLEAR: begin
                    chg = cur.power || (cur.remaining != '0) || cur.pending;
                    nxt.power      = 1'b0;
                    nxt.fan        = 3'd1;
                    nxt.mist       = 1'b0;
                    nxt.breeze     = '0;
                    nxt.swing      = '0;
                    nxt.direction  = '0;
                    nxt.remaining  = '0;
                    nxt.duration   = '0;
                    nxt.pending    = 1'b0;
                    nxt.timer_mark = cur.now_uptime;
                end
                default: begin
                    chg = 1'b0;
                end
            endcase
            if (chg) begin
                nxt.revision = cur.revision + 32'd1;
                nxt.source   = c_org;
                status       = acarb_pkg::ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/appliance_command_arbiter.sv
// Top level of the appliance command arbiter: input register, control state, result register.
// Depends on acarb_pkg, acarb_dedup and acarb_eval.
//
// Usage: each beat on the s_axis channel is one request (a command, a power toggle, a timer
// tick with the current uptime, or completion of a timer shutdown), selected by s_axis_tuser.
// Every request yields exactly one beat on the m_axis channel carrying the status in
// m_axis_tuser and the full control state after the request in m_axis_tdata.
// A request is accepted into the input register, and its result is registered in the output
// register when the request leaves the input register. One request is taken every cycle
// while the receiver keeps taking results, since a request is evaluated and the state
// updated in the cycle it leaves the input register.
// When the receiver stalls, the result is held in the output register and one further beat
// may wait in the input register; s_axis_tready then falls until the result is taken.
// cfg_wen writes the provisioning lock from cfg_wdata; write it only while the block is idle.
// Reset powers the appliance off with fan speed one and all modes cleared, stops the timer,
// zeroes the revision, clears the lock and forgets all request serials.
`default_nettype none

module appliance_command_arbiter #(
    parameter int unsigned ORIGINS = acarb_pkg::ORIGINS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // origin, request_id, cmd_kind, cmd_value, uptime_seconds, zero padding
    input  wire logic [79:0] s_axis_tdata,
    // req_type
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // power_on, fan_speed, mist_mode, breeze_mode, swing_mode, direction,
    // timer_remaining, timer_duration, shutdown_pending, revision, last_source, zero padding
    output logic [71:0]      m_axis_tdata,
    // status
    output logic [2:0]       m_axis_tuser
);

    acarb_pkg::item_t       s_item;
    acarb_pkg::item_t       in_item_reg;
    logic                   in_valid_reg;
    logic                   out_valid_reg;
    logic [71:0]            out_data_reg;
    acarb_pkg::status_t     out_status_reg;
    acarb_pkg::ctl_state_t  state_reg;
    acarb_pkg::ctl_state_t  state_next;
    acarb_pkg::status_t     status_next;
    logic [71:0]            data_next;
    logic                   lock_reg;
    logic                   advance;
    logic                   fire;
    acarb_pkg::dedup_look_t dd_look;
    acarb_pkg::dedup_upd_t  ev_upd;
    acarb_pkg::dedup_upd_t  dd_upd;

    assign s_item.req_type       = s_axis_tuser;
    assign s_item.origin         = s_axis_tdata[1:0];
    assign s_item.request_id     = s_axis_tdata[33:2];
    assign s_item.cmd_kind       = s_axis_tdata[37:34];
    assign s_item.cmd_value      = s_axis_tdata[45:38];
    assign s_item.uptime_seconds = s_axis_tdata[77:46];

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg <= 1'b0;
        end else if (cfg_wen) begin
            lock_reg <= cfg_wdata;
        end
    end

    acarb_dedup #(
        .ORIGINS (ORIGINS)
    ) u_dedup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .look_org (in_item_reg.origin),
        .look_id  (in_item_reg.request_id),
        .look     (dd_look),
        .upd      (dd_upd)
    );

    acarb_eval u_eval (
        .item   (in_item_reg),
        .cur    (state_reg),
        .lock   (lock_reg),
        .look   (dd_look),
        .nxt    (state_next),
        .status (status_next),
        .upd    (ev_upd)
    );

    assign dd_upd.wr_en  = ev_upd.wr_en && fire;
    assign dd_upd.origin = ev_upd.origin;
    assign dd_upd.id     = ev_upd.id;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= acarb_pkg::CTL_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign data_next = {1'b0, state_next.source, state_next.revision, state_next.pending,
                        state_next.duration, state_next.remaining, state_next.direction,
                        state_next.swing, state_next.breeze, state_next.mist,
                        state_next.fan, state_next.power};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg   <= data_next;
            out_status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    a_rev_idle: assert property (@(posedge aclk)
        aresetn && !fire |=> $stable(state_reg.revision))
        else $error("revision moved without a request");

    a_rev_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && fire |=> ((out_status_reg == acarb_pkg::ST_OK)
                             == (state_reg.revision == $past(state_reg.revision) + 32'd1)))
        else $error("revision step disagrees with status");

    a_pend_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending |-> (state_reg.remaining == '0))
        else $error("shutdown pending with timer still running");

    a_off_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.power |-> (state_reg.fan == 3'd1) && !state_reg.mist
                             && (state_reg.breeze == '0) && (state_reg.swing == '0)
                             && (state_reg.direction == '0))
        else $error("motion settings kept while powered off");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the appliance command arbiter: directed beats, then random phases.
// Results are compared with an in-bench prediction of the appliance state; needs acarb_pkg
// and the arbiter RTL only.
`timescale 1ns / 1ps

module tb_top;
    import acarb_pkg::*;

    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        status_t           status;
        logic              power;
        logic [2:0]        fan;
        logic              mist;
        logic [2:0]        breeze;
        logic [1:0]        swing;
        logic signed [1:0] direction;
        logic [11:0]       remaining;
        logic [11:0]       duration;
        logic              pending;
        logic [31:0]       revision;
        logic [1:0]        source;
    } appliance_view_t;

    typedef struct packed {
        req_t              rt;
        logic [1:0]        origin;
        logic [31:0]       rid;
        kind_t             kind;
        logic signed [7:0] value;
        logic [31:0]       uptime;
        logic              typed;
        status_t           status;
        logic              flip_lock;
    } request_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wen;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Predicted appliance state.
    logic              lock_q;
    logic              app_power;
    logic [2:0]        app_fan;
    logic              app_mist;
    logic [2:0]        app_breeze;
    logic [1:0]        app_swing;
    logic signed [1:0] app_dir;
    logic [11:0]       app_left;
    logic [11:0]       app_set;
    logic              app_shutdown;
    logic [31:0]       app_mark;
    logic [31:0]       app_clock;
    logic              app_seen [4];
    logic [31:0]       app_last_id [4];
    logic [31:0]       app_rev;
    logic [1:0]        app_src;

    appliance_view_t predicted_views [$];

    int  mismatches = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  lock_writes = 0;
    int  status_seen [5] = '{default: 0};
    int  quiet_cycles = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;
    int  holds_done = 0;

    request_row_t directed_rows [27] = '{
        '{REQ_CMD,    2'd1, 32'd0,          K_POWER,     8'sd1,   32'd0, 1'b1, ST_BADVALUE, 1'b0},
        '{REQ_CMD,    2'd1, 32'd1,          K_FAN,       8'sd3,   32'd0, 1'b1, ST_BADTRANS, 1'b0},
        '{REQ_CMD,    2'd1, 32'd1,          K_POWER,     8'sd1,   32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd1, 32'd1,          K_FAN,       8'sd5,   32'd0, 1'b1, ST_DUP,      1'b0},
        '{REQ_CMD,    2'd1, 32'd2,          K_FAN,       8'sd6,   32'd0, 1'b1, ST_BADVALUE, 1'b0},
        '{REQ_CMD,    2'd1, 32'd2,          K_FAN,       8'sd5,   32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd2, 32'hFFFF_FFFF,  K_MIST,      8'sd1,   32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd2, 32'h7FFF_FFFF,  K_MIST,      8'sd0,   32'd0, 1'b1, ST_DUP,      1'b0},
        '{REQ_CMD,    2'd2, 32'd1,          K_BREEZE,    8'sd6,   32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd3, 32'd5,          K_SWING,     8'sd3,   32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd3, 32'd6,          K_DIR,       -8'sd1,  32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd3, 32'd7,          K_POS,       -8'sd3,  32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd3, 32'd8,          K_POS,       8'sh80,  32'd0, 1'b1, ST_BADVALUE, 1'b0},
        '{REQ_CMD,    2'd0, 32'd0,          4'd15,       8'sd127, 32'd0, 1'b1, ST_BADVALUE, 1'b0},
        '{REQ_CMD,    2'd0, 32'd0,          K_TIMER,     8'sd15,  32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_TICK,   2'd0, 32'd0,          K_POWER,     8'sd0,   32'd100, 1'b0, ST_OK,     1'b0},
        '{REQ_TICK,   2'd0, 32'd0,          K_POWER,     8'sd0,   32'd100, 1'b1, ST_NOCHANGE, 1'b0},
        '{REQ_DONE,   2'd0, 32'd0,          K_POWER,     8'sd0,   32'd0, 1'b1, ST_BADTRANS, 1'b0},
        '{REQ_TICK,   2'd0, 32'd0,          K_POWER,     8'sd0,   32'hFFFF_FFFF, 1'b0, ST_OK, 1'b0},
        '{REQ_DONE,   2'd0, 32'd0,          K_POWER,     8'sd0,   32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_TOGGLE, 2'd1, 32'd3,          K_POWER,     8'sd0,   32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd1, 32'd4,          K_CLEAR,     8'sd0,   32'd0, 1'b0, ST_OK,       1'b0},
        '{REQ_CMD,    2'd1, 32'd5,          K_CLEAR,     8'sd0,   32'd0, 1'b1, ST_NOCHANGE, 1'b0},
        '{REQ_CMD,    2'd0, 32'd9,          K_POWER,     8'sd0,   32'd0, 1'b1, ST_NOCHANGE, 1'b0},
        '{REQ_CMD,    2'd0, 32'd9,          K_POWER,     8'sd1,   32'd0, 1'b1, ST_DUP,      1'b0},
        '{REQ_CMD,    2'd1, 32'd100,        K_POWER,     8'sd1,   32'd0, 1'b1, ST_BADTRANS, 1'b1},
        '{REQ_CMD,    2'd0, 32'd0,          K_POWER,     8'sd1,   32'd0, 1'b0, ST_OK,       1'b0}
    };

    int lock_plan  [5] = '{0, 1, 0, 1, 0};
    int phase_size [5] = '{260, 120, 260, 60, 200};

    appliance_command_arbiter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void reset_appliance();
        lock_q       = 1'b0;
        app_power    = 1'b0;
        app_fan      = 3'd1;
        app_mist     = 1'b0;
        app_breeze   = 3'd0;
        app_swing    = 2'd0;
        app_dir      = 2'sd0;
        app_left     = 12'd0;
        app_set      = 12'd0;
        app_shutdown = 1'b0;
        app_mark     = 32'd0;
        app_clock    = 32'd0;
        app_rev      = 32'd0;
        app_src      = ORG_SYSTEM;
        for (int i = 0; i < 4; i++) begin
            app_seen[i]    = 1'b0;
            app_last_id[i] = 32'd0;
        end
    endfunction

    function automatic void stop_motion();
        app_fan    = 3'd1;
        app_mist   = 1'b0;
        app_breeze = 3'd0;
        app_swing  = 2'd0;
        app_dir    = 2'sd0;
    endfunction

    function automatic logic value_allowed(kind_t k, logic signed [7:0] v);
        int iv;
        iv = v;
        case (k)
            K_POWER:  return iv == 0 || iv == 1;
            K_FAN:    return iv >= 1 && iv <= 5;
            K_MIST:   return iv >= 0 && iv <= 1;
            K_BREEZE: return iv >= 0 && iv <= 6;
            K_SWING:  return iv >= 0 && iv <= 3;
            K_DIR:    return iv >= -1 && iv <= 1;
            K_POS:    return iv >= -3 && iv <= 3;
            K_TIMER:  return iv == 0 || iv == 15 || iv == 30 || iv == 45 || iv == 60;
            K_CLEAR:  return iv == 0;
            default:  return 1'b0;
        endcase
    endfunction

    // Returns whether the command altered the appliance state.
    function automatic logic apply_command(kind_t k, logic signed [7:0] v);
        logic        changed;
        logic        want_on;
        logic [11:0] secs;
        case (k)
            K_POWER: begin
                want_on = (v != 8'sd0);
                changed = app_power != want_on || app_left != 12'd0 || app_shutdown;
                app_left     = 12'd0;
                app_set      = 12'd0;
                app_shutdown = 1'b0;
                app_mark     = app_clock;
                if (!changed) return 1'b0;
                app_power = want_on;
                if (!want_on) stop_motion();
                return 1'b1;
            end
            K_FAN: begin
                changed    = app_fan != v[2:0] || app_breeze != 3'd0;
                app_fan    = v[2:0];
                app_breeze = 3'd0;
                return changed;
            end
            K_MIST: begin
                if (app_mist == v[0]) return 1'b0;
                app_mist = v[0];
                return 1'b1;
            end
            K_BREEZE: begin
                if (app_breeze == v[2:0]) return 1'b0;
                app_breeze = v[2:0];
                return 1'b1;
            end
            K_SWING: begin
                if (app_swing == v[1:0]) return 1'b0;
                app_swing = v[1:0];
                return 1'b1;
            end
            K_DIR: begin
                app_dir   = v[1:0];
                app_swing = 2'd0;
                return 1'b1;
            end
            K_POS: begin
                app_swing = 2'd0;
                return 1'b1;
            end
            K_TIMER: begin
                secs = 12'(int'(v) * 60);
                if (app_left == secs && !app_shutdown) return 1'b0;
                app_left     = secs;
                app_set      = secs;
                app_mark     = app_clock;
                app_shutdown = 1'b0;
                return 1'b1;
            end
            K_CLEAR: begin
                changed = app_power || app_left != 12'd0 || app_shutdown;
                app_power = 1'b0;
                stop_motion();
                app_left     = 12'd0;
                app_set      = 12'd0;
                app_shutdown = 1'b0;
                app_mark     = app_clock;
                return changed;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic status_t run_command(logic [1:0] org, logic [31:0] rid, kind_t k,
                                            logic signed [7:0] v);
        logic [31:0] ahead;
        if (org != ORG_SYSTEM && rid == 32'd0) return ST_BADVALUE;
        if (org != ORG_SYSTEM && lock_q) return ST_BADTRANS;
        if (rid != 32'd0 && app_seen[org]) begin
            ahead = rid - app_last_id[org];
            if (ahead == 32'd0 || ahead[31]) return ST_DUP;
        end
        if (!value_allowed(k, v)) return ST_BADVALUE;
        if (k != K_POWER && k != K_CLEAR && !app_power) return ST_BADTRANS;
        if (rid != 32'd0) begin
            app_seen[org]    = 1'b1;
            app_last_id[org] = rid;
        end
        if (!apply_command(k, v)) return ST_NOCHANGE;
        app_rev = app_rev + 32'd1;
        app_src = org;
        return ST_OK;
    endfunction

    function automatic status_t run_tick(logic [31:0] up);
        logic [31:0] elapsed;
        if (!app_power || app_left == 12'd0 || app_shutdown) begin
            app_mark = up;
            return ST_NOCHANGE;
        end
        elapsed = up - app_mark;
        if (elapsed == 32'd0) return ST_NOCHANGE;
        app_mark = up;
        if (elapsed >= 32'(app_left)) begin
            app_left     = 12'd0;
            app_swing    = 2'd0;
            app_dir      = 2'sd0;
            app_shutdown = 1'b1;
        end else begin
            app_left = app_left - elapsed[11:0];
        end
        app_rev = app_rev + 32'd1;
        app_src = ORG_SYSTEM;
        return ST_OK;
    endfunction

    function automatic appliance_view_t predict_request(req_t rt, logic [1:0] org,
                                                        logic [31:0] rid, kind_t k,
                                                        logic signed [7:0] v,
                                                        logic [31:0] up);
        appliance_view_t view;
        case (rt)
            REQ_CMD:    view.status = run_command(org, rid, k, v);
            REQ_TOGGLE: view.status = run_command(org, rid, K_POWER,
                                                  app_power ? 8'sd0 : 8'sd1);
            REQ_TICK: begin
                app_clock   = up;
                view.status = run_tick(up);
            end
            default: begin
                if (!app_shutdown) view.status = ST_BADTRANS;
                else view.status = run_command(ORG_SYSTEM, 32'd0, K_POWER, 8'sd0);
            end
        endcase
        view.power     = app_power;
        view.fan       = app_fan;
        view.mist      = app_mist;
        view.breeze    = app_breeze;
        view.swing     = app_swing;
        view.direction = app_dir;
        view.remaining = app_left;
        view.duration  = app_set;
        view.pending   = app_shutdown;
        view.revision  = app_rev;
        view.source    = app_src;
        return view;
    endfunction

    function automatic string describe(appliance_view_t v);
        return $sformatf({"status=%0d power=%0d fan=%0d mist=%0d breeze=%0d swing=%0d ",
                          "dir=%0d left=%0d set=%0d pending=%0d rev=%0d source=%0d"},
                         v.status, v.power, v.fan, v.mist, v.breeze, v.swing, v.direction,
                         v.remaining, v.duration, v.pending, v.revision, v.source);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_id(logic [1:0] org);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'd0;
        if (r < 11) return app_last_id[org] - $urandom_range(0, 4);
        if (r < 14) return $urandom;
        if (r < 18) return app_last_id[org] + $urandom_range(1, 32'h7FFF_FFFF);
        return app_last_id[org] + $urandom_range(1, 3);
    endfunction

    function automatic logic signed [7:0] pick_value(kind_t k);
        if ($urandom_range(0, 99) < 15) return 8'($urandom);
        case (k)
            K_POWER:  return 8'($urandom_range(0, 1));
            K_FAN:    return 8'($urandom_range(1, 5));
            K_MIST:   return 8'($urandom_range(0, 1));
            K_BREEZE: return 8'($urandom_range(0, 6));
            K_SWING:  return 8'($urandom_range(0, 3));
            K_DIR:    return 8'(int'($urandom_range(0, 2)) - 1);
            K_POS:    return 8'(int'($urandom_range(0, 6)) - 3);
            K_TIMER:  return 8'(15 * int'($urandom_range(0, 4)));
            K_CLEAR:  return 8'sd0;
            default:  return 8'($urandom);
        endcase
    endfunction

    task automatic send_beat(input req_t rt, input logic [1:0] org, input logic [31:0] rid,
                             input kind_t k, input logic signed [7:0] v,
                             input logic [31:0] up, input logic typed,
                             input status_t typed_status);
        appliance_view_t view;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rt;
        s_axis_tdata  <= {2'b00, up, v, k, rid, org};
        do @(posedge aclk); while (!s_axis_tready);
        view = predict_request(rt, org, rid, k, v, up);
        if (typed) view.status = typed_status;
        predicted_views.push_back(view);
        beats_sent++;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_lock(input logic value);
        s_axis_tvalid <= 1'b0;
        while (predicted_views.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        lock_q = value;
        lock_writes++;
    endtask

    task automatic random_beat();
        int                r;
        logic [1:0]        org;
        logic [31:0]       rid;
        logic [31:0]       up;
        kind_t             k;
        logic signed [7:0] v;
        req_t              rt;
        r   = $urandom_range(0, 99);
        org = 2'($urandom_range(0, 3));
        rid = pick_id(org);
        if (org == ORG_SYSTEM && $urandom_range(0, 1) == 1) rid = 32'd0;
        if ($urandom_range(0, 9) == 0) k = kind_t'($urandom_range(9, 15));
        else k = kind_t'($urandom_range(0, 8));
        v = pick_value(k);
        if (!app_power && $urandom_range(0, 1) == 1) begin
            k = K_POWER;
            v = 8'sd1;
        end
        up = $urandom;
        if (r < 55) begin
            rt = REQ_CMD;
        end else if (r < 65) begin
            rt = REQ_TOGGLE;
        end else if (r < 90) begin
            rt = REQ_TICK;
            case ($urandom_range(0, 9))
                0:       up = $urandom;
                1:       up = app_clock;
                default: up = app_clock + $urandom_range(1, 1200);
            endcase
        end else begin
            rt = REQ_DONE;
        end
        send_beat(rt, org, rid, k, v, up, 1'b0, ST_OK);
    endtask

    // Result side: every accepted beat is matched with the oldest prediction.
    always @(posedge aclk) begin
        appliance_view_t got;
        appliance_view_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status    = m_axis_tuser;
            got.power     = m_axis_tdata[0];
            got.fan       = m_axis_tdata[3:1];
            got.mist      = m_axis_tdata[4];
            got.breeze    = m_axis_tdata[7:5];
            got.swing     = m_axis_tdata[9:8];
            got.direction = m_axis_tdata[11:10];
            got.remaining = m_axis_tdata[23:12];
            got.duration  = m_axis_tdata[35:24];
            got.pending   = m_axis_tdata[36];
            got.revision  = m_axis_tdata[68:37];
            got.source    = m_axis_tdata[70:69];
            if (predicted_views.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result beat: %s", describe(got));
            end else begin
                want = predicted_views.pop_front();
                if (want.status <= ST_DUP) status_seen[want.status]++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Result beat %0d differs", beats_checked);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
            end
            beats_checked++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else if (steady) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 99) < 65) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 3)) @(posedge aclk);
            end
        end
    end

    initial begin
        aresetn       <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_CMD;
        reset_appliance();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].flip_lock) write_lock(!lock_q);
            send_beat(directed_rows[i].rt, directed_rows[i].origin, directed_rows[i].rid,
                      directed_rows[i].kind, directed_rows[i].value, directed_rows[i].uptime,
                      directed_rows[i].typed, directed_rows[i].status);
        end

        for (int p = 0; p < 5; p++) begin
            write_lock(lock_plan[p][0]);
            steady = (p == 2);
            for (int n = 0; n < phase_size[p]; n++) begin
                if (p == 0 && n == 80) hold_req = 1'b1;
                random_beat();
            end
            steady = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        while (predicted_views.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (predicted_views.size() != 0) mismatches++;
        $display("Sent %0d request beats (%0d directed) and checked %0d results over %0d lock writes.",
                 beats_sent, $size(directed_rows), beats_checked, lock_writes);
        $display("Statuses: ok %0d, unchanged %0d, bad value %0d, bad transition %0d, dup %0d; holds %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
                 holds_done);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
